// File: hdl/rcpb_pkg.sv
// Shared types, constants and the hop list derivation for the RC packet builder.
// Used by rcpb_div and rc_packet_builder_hopper; depends on nothing else.
`default_nettype none

package rcpb_pkg;

  localparam int HOP_CHANNELS = 4;
  localparam int PACKET_BYTES = 10;
  localparam int STICK_W      = 12;
  // Numerator holds a 12-bit difference times an 8-bit factor.
  localparam int NUM_W        = STICK_W + 8;
  localparam int DEN_W        = STICK_W;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 32;

  // Commands carried in the input item.
  localparam logic [1:0] CMD_DATA   = 2'd0;
  localparam logic [1:0] CMD_BIND   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_MIN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_MID     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_MAX     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSMITTER_ID = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_MASK    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PICTURE_MASK  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_MASK     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADLESS_MASK = 4'd7;

  // Fixed packet bytes.
  localparam logic [7:0] BIND_HEAD   = 8'ha2;
  localparam logic [7:0] BIND_FILL   = 8'haa;
  localparam logic [7:0] ELE_TRIM    = 8'hc0;
  localparam logic [7:0] CHECK_BIAS  = 8'h55;
  localparam logic [7:0] SPAN_HIGH   = 8'h80;
  localparam logic [7:0] SPAN_LOW    = 8'h00;
  localparam logic [7:0] THR_FACTOR  = 8'd255;
  localparam logic [7:0] STICK_FACTOR = 8'd127;

  typedef logic [HOP_CHANNELS-1:0][7:0] hop_list_t;

  // Channel tables, entry 0 in the low byte.
  localparam hop_list_t HOP_RESET = 32'h20_40_30_4b;
  localparam hop_list_t BASE_LOW  = 32'h3a_2a_1a_0a;
  localparam hop_list_t BASE_MID  = 32'h22_42_0a_2a;
  localparam hop_list_t BASE_HIGH = 32'h32_12_3a_1a;
  localparam hop_list_t LIST_1E   = 32'h38184121;
  localparam hop_list_t LIST_1F   = 32'h39194121;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [STICK_W-1:0] throttle;
    logic [STICK_W-1:0] elevator;
    logic [STICK_W-1:0] rudder;
    logic [STICK_W-1:0] aileron;
    logic               video_on;
    logic               picture_on;
    logic               flip_on;
    logic               headless_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
    logic [7:0] byte8;
    logic [7:0] check_byte;
    logic [7:0] rf_channel;
  } out_item_t;

  // Divider handshake between the sequencer and the shared unit.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Hop list from the low five bits of the transmitter id.
  function automatic hop_list_t hop_derive(input logic [4:0] l);
    hop_list_t  h;
    logic [4:0] lv;
    int         i;
    h  = HOP_RESET;
    lv = l;
    if (l < 5'h10) begin
      if (l == 5'h06) lv = 5'h07;
      for (i = 0; i < HOP_CHANNELS; i++) h[i] = BASE_LOW[i] + {3'b000, lv};
    end else if (l < 5'h18) begin
      for (i = 0; i < HOP_CHANNELS; i++) h[i] = BASE_MID[i] + {5'b00000, l[2:0]};
      if (l == 5'h16) begin
        h[0] = h[0] + 8'd1;
        h[1] = h[1] + 8'd1;
      end
    end else if (l < 5'h1e) begin
      for (i = 0; i < HOP_CHANNELS; i++) h[i] = BASE_HIGH[i] + {5'b00000, l[2:0]};
    end else if (l == 5'h1e) begin
      h = LIST_1E;
    end else begin
      h = LIST_1F;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rcpb_div.sv
// Shared iterative unsigned divider for the stick and throttle maps.
// Retires STEPS quotient bits per cycle; depends on rcpb_pkg.
`default_nettype none

module rcpb_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 12,
  parameter int STEPS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rcpb_pkg::div_ctl_t  ctl,
  input  wire logic [NUM_W-1:0]    numer,
  input  wire logic [DEN_W-1:0]    denom,
  output      rcpb_pkg::div_sts_t  sts,
  output      logic [NUM_W-1:0]    quot
);

  localparam int ITERS = NUM_W / STEPS;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] q_nxt;
  logic [DEN_W-1:0] rem_nxt;

  // Several restoring steps in one cycle: shift in a bit, subtract if it fits.
  always_comb begin
    logic [DEN_W:0]   rem_w;
    logic [NUM_W-1:0] q_w;
    rem_w = {1'b0, rem_r};
    q_w   = q_r;
    for (int s = 0; s < STEPS; s++) begin
      rem_w = {rem_w[DEN_W-1:0], q_w[NUM_W-1]};
      q_w   = {q_w[NUM_W-2:0], 1'b0};
      if (rem_w >= {1'b0, den_r}) begin
        rem_w  = rem_w - {1'b0, den_r};
        q_w[0] = 1'b1;
      end
    end
    q_nxt   = q_w;
    rem_nxt = rem_w[DEN_W-1:0];
  end

  // Iteration control and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ITERS);
        q_r    <= numer;
        rem_r  <= '0;
        den_r  <= denom;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = q_r;

  // A finished quotient always follows a run of iterations.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a preceding iteration");

  // The sequencer never restarts a division that is still running.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.start && busy_r))
    else $error("divider started while busy");

endmodule

`default_nettype wire

// File: hdl/rc_packet_builder_hopper.sv
// Top level of the RC packet builder and channel hopper.
// Depends on rcpb_pkg and the shared divider rcpb_div.
//
// Usage: an item on the in_ channel (in_valid, in_stall, in_data) is taken
// when in_valid is high and in_stall is low. in_stall is high while an item
// is being worked on, so one item is handled at a time. A data item runs four
// maps (throttle, elevator, rudder, aileron) through one shared divider; each
// map passes a setup state, then waits in the divide state until the divider
// reports done and its byte is stored. A map whose span is empty skips the
// divider and stores its base from the setup state. After the last map the
// packet is loaded from the emit state into the output register. A bind item
// goes straight to the emit state. A finish-bind item updates the hop list at
// its transfer and gives no result. The divider retires four quotient bits per
// cycle.
// Results sit in an output register: out_valid stays high and out_data holds
// while out_stall is high; a new item is accepted meanwhile, and its packet
// waits for the register to free up. Configuration writes (cfg_valid,
// cfg_ready, cfg_index, cfg_data) are always accepted and belong in idle time.
// Synchronous reset restores the register defaults and the reset hop list and
// clears the hop position.
`default_nettype none

module rc_packet_builder_hopper (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire rcpb_pkg::in_item_t                 in_data,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      rcpb_pkg::out_item_t                out_data,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [rcpb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rcpb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW = rcpb_pkg::STICK_W;

  // Map slots, in the order the sequencer visits them.
  localparam logic [1:0] K_THR = 2'd0;
  localparam logic [1:0] K_ELE = 2'd1;
  localparam logic [1:0] K_RUD = 2'd2;
  localparam logic [1:0] K_AIL = 2'd3;

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_DIV, S_EMIT} state_t;

  state_t                         state_r;
  logic [1:0]                     k_r;
  rcpb_pkg::in_item_t             in_r;
  logic [3:0][7:0]                res_r;
  logic [7:0]                     c_r;
  logic                           neg_r;
  logic [SW-1:0]                  stick_min_r;
  logic [SW-1:0]                  stick_mid_r;
  logic [SW-1:0]                  stick_max_r;
  logic [31:0]                    tid_r;
  logic [7:0]                     video_mask_r;
  logic [7:0]                     picture_mask_r;
  logic [7:0]                     flip_mask_r;
  logic [7:0]                     headless_mask_r;
  rcpb_pkg::hop_list_t            hop_list_r;
  logic [1:0]                     hop_idx_r;
  logic                           parity_r;
  logic                           out_valid_r;
  rcpb_pkg::out_item_t            out_r;

  logic                           in_fire;
  logic                           out_load;
  rcpb_pkg::div_ctl_t             div_ctl;
  rcpb_pkg::div_sts_t             div_sts;
  logic [rcpb_pkg::NUM_W-1:0]     div_q;
  logic [rcpb_pkg::NUM_W-1:0]     prod;
  logic [SW-1:0]                  m_dx;
  logic [7:0]                     m_fac;
  logic [SW-1:0]                  m_den;
  logic                           m_degen;
  logic [7:0]                     m_c;
  logic                           m_neg;
  logic [7:0]                     map_byte;
  rcpb_pkg::out_item_t            pkt;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // Operands of the current map: difference, factor, divisor and output base.
  always_comb begin
    logic [SW-1:0] sx;
    logic [SW-1:0] sb;
    logic [SW-1:0] tc;
    logic          lt;
    sx      = in_r.elevator;
    sb      = stick_max_r;
    tc      = in_r.throttle;
    lt      = 1'b0;
    m_dx    = '0;
    m_fac   = rcpb_pkg::STICK_FACTOR;
    m_den   = '0;
    m_degen = 1'b1;
    m_c     = rcpb_pkg::SPAN_LOW;
    m_neg   = 1'b0;
    case (k_r)
      K_THR: begin
        // Clamp to the configured range, then scale to a full byte.
        if (tc < stick_min_r) tc = stick_min_r;
        if (tc > stick_max_r) tc = stick_max_r;
        m_dx    = tc - stick_min_r;
        m_fac   = rcpb_pkg::THR_FACTOR;
        m_den   = stick_max_r - stick_min_r;
        m_degen = (stick_max_r <= stick_min_r);
      end
      K_ELE, K_RUD, K_AIL: begin
        if (k_r == K_RUD) sx = in_r.rudder;
        else if (k_r == K_AIL) sx = in_r.aileron;
        lt = (sx < stick_mid_r);
        sb = lt ? stick_min_r : stick_max_r;
        // Elevator puts the direction bit below center, the others above.
        if (k_r == K_ELE) m_c = lt ? rcpb_pkg::SPAN_HIGH : rcpb_pkg::SPAN_LOW;
        else m_c = lt ? rcpb_pkg::SPAN_LOW : rcpb_pkg::SPAN_HIGH;
        m_dx    = lt ? (stick_mid_r - sx) : (sx - stick_mid_r);
        m_den   = (sb < stick_mid_r) ? (stick_mid_r - sb) : (sb - stick_mid_r);
        m_degen = (sb == stick_mid_r);
        m_neg   = lt ^ (sb < stick_mid_r);
      end
      default: begin
        m_degen = 1'b1;
      end
    endcase
  end

  // The one multiplier; its product is captured by the divider at start.
  assign prod = rcpb_pkg::NUM_W'(m_dx) * rcpb_pkg::NUM_W'(m_fac);

  assign div_ctl.start = (state_r == S_SETUP) && !m_degen;

  rcpb_div #(
    .NUM_W (rcpb_pkg::NUM_W),
    .DEN_W (rcpb_pkg::DEN_W),
    .STEPS (4)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .numer (prod),
    .denom (m_den),
    .sts   (div_sts),
    .quot  (div_q)
  );

  // Truncated signed quotient plus base; only the low byte is kept.
  assign map_byte = c_r + (neg_r ? (8'd0 - div_q[7:0]) : div_q[7:0]);

  // Packet assembly from the stored maps or the bind fields.
  always_comb begin
    logic [rcpb_pkg::PACKET_BYTES-2:0][7:0] p;
    logic [7:0]                             x;
    p = '0;
    if (in_r.cmd == rcpb_pkg::CMD_BIND) begin
      p[0] = rcpb_pkg::BIND_HEAD;
      p[1] = tid_r[31:24];
      p[2] = tid_r[23:16];
      p[3] = tid_r[15:8];
      p[4] = tid_r[7:0];
      p[5] = rcpb_pkg::BIND_FILL;
      p[6] = rcpb_pkg::BIND_FILL;
      p[7] = rcpb_pkg::BIND_FILL;
    end else begin
      p[0] = res_r[K_THR];
      p[1] = res_r[K_ELE];
      p[2] = res_r[K_RUD];
      p[3] = res_r[K_AIL];
      p[4] = (in_r.video_on ? video_mask_r : 8'h00) |
             (in_r.picture_on ? picture_mask_r : 8'h00);
      p[5] = (res_r[K_ELE] >> 2) | rcpb_pkg::ELE_TRIM;
      p[6] = (res_r[K_RUD] >> 2) | (in_r.flip_on ? flip_mask_r : 8'h00);
      p[7] = (res_r[K_AIL] >> 2) | (in_r.headless_on ? headless_mask_r : 8'h00);
    end
    x = '0;
    for (int i = 0; i < rcpb_pkg::PACKET_BYTES - 1; i++) x = x ^ p[i];
    pkt.byte0      = p[0];
    pkt.byte1      = p[1];
    pkt.byte2      = p[2];
    pkt.byte3      = p[3];
    pkt.byte4      = p[4];
    pkt.byte5      = p[5];
    pkt.byte6      = p[6];
    pkt.byte7      = p[7];
    pkt.byte8      = p[8];
    pkt.check_byte = x + rcpb_pkg::CHECK_BIAS;
    pkt.rf_channel = hop_list_r[hop_idx_r];
  end

  // Sequencer, configuration, hop state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      k_r             <= K_THR;
      stick_min_r     <= 12'd1000;
      stick_mid_r     <= 12'd1500;
      stick_max_r     <= 12'd2000;
      tid_r           <= '0;
      video_mask_r    <= 8'h10;
      picture_mask_r  <= 8'h08;
      flip_mask_r     <= 8'h40;
      headless_mask_r <= 8'h80;
      hop_list_r      <= rcpb_pkg::HOP_RESET;
      hop_idx_r       <= '0;
      parity_r        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rcpb_pkg::CFG_STICK_MIN:      stick_min_r     <= cfg_data[SW-1:0];
          rcpb_pkg::CFG_STICK_MID:      stick_mid_r     <= cfg_data[SW-1:0];
          rcpb_pkg::CFG_STICK_MAX:      stick_max_r     <= cfg_data[SW-1:0];
          rcpb_pkg::CFG_TRANSMITTER_ID: tid_r           <= cfg_data;
          rcpb_pkg::CFG_VIDEO_MASK:     video_mask_r    <= cfg_data[7:0];
          rcpb_pkg::CFG_PICTURE_MASK:   picture_mask_r  <= cfg_data[7:0];
          rcpb_pkg::CFG_FLIP_MASK:      flip_mask_r     <= cfg_data[7:0];
          rcpb_pkg::CFG_HEADLESS_MASK:  headless_mask_r <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            in_r <= in_data;
            k_r  <= K_THR;
            case (in_data.cmd)
              rcpb_pkg::CMD_DATA: state_r <= S_SETUP;
              rcpb_pkg::CMD_BIND: state_r <= S_EMIT;
              rcpb_pkg::CMD_FINISH: begin
                hop_list_r <= rcpb_pkg::hop_derive(tid_r[4:0]);
                hop_idx_r  <= '0;
                parity_r   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_SETUP: begin
          c_r   <= m_c;
          neg_r <= m_neg;
          if (m_degen) begin
            // Empty span: the map gives its output base directly.
            res_r[k_r] <= m_c;
            if (k_r == K_AIL) state_r <= S_EMIT;
            else k_r <= k_r + 2'd1;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            res_r[k_r] <= map_byte;
            if (k_r == K_AIL) begin
              state_r <= S_EMIT;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_SETUP;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_r       <= pkt;
            out_valid_r <= 1'b1;
            if (parity_r) hop_idx_r <= hop_idx_r + 2'd1;
            parity_r <= !parity_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Each delivered packet flips the repeat parity.
  a_parity_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (parity_r != $past(parity_r)))
    else $error("repeat parity did not toggle on a packet");

  // Only data and bind items produce a packet.
  a_load_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (in_r.cmd == rcpb_pkg::CMD_DATA || in_r.cmd == rcpb_pkg::CMD_BIND))
    else $error("packet loaded for a command without a result");

  // Finishing a bind restarts the hop sequence.
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.cmd == rcpb_pkg::CMD_FINISH) |=> (hop_idx_r == 2'd0 && !parity_r))
    else $error("finish bind did not clear the hop position");

endmodule

`default_nettype wire

// File: test/rcpb_packet_checker.sv
// Scoreboard for the RC packet builder: watches the input, result and register channels,
// keeps its own copy of the sticks, masks and hop state, and checks every packet.
// Depends on rcpb_pkg for the item types, command codes and register indexes.

module rcpb_packet_checker
  import rcpb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire in_item_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire out_item_t             out_data,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending_count,
  output int                         checked_count
);

  // Fixed packet bytes.
  localparam logic [7:0] PKT_BIND_HEAD = 8'ha2;
  localparam logic [7:0] PKT_BIND_FILL = 8'haa;
  localparam logic [7:0] PKT_ELE_TRIM  = 8'hc0;
  localparam logic [7:0] PKT_CHECK_ADD = 8'h55;
  localparam int         OUT_FIELDS    = 11;

  // Channel tables, entry 0 in the low byte.
  localparam logic [31:0] HOPS_AT_RESET = 32'h20_40_30_4b;
  localparam logic [31:0] HOPS_LOW      = 32'h3a_2a_1a_0a;
  localparam logic [31:0] HOPS_MID      = 32'h22_42_0a_2a;
  localparam logic [31:0] HOPS_HIGH     = 32'h32_12_3a_1a;
  localparam logic [31:0] HOPS_SEED_1E  = 32'h38_18_41_21;
  localparam logic [31:0] HOPS_SEED_1F  = 32'h39_19_41_21;

  // Register copies.
  logic [11:0] cfg_min, cfg_mid, cfg_max;
  logic [31:0] tx_id;
  logic [7:0]  vid_mask, pic_mask, flp_mask, hdl_mask;

  // Hop state.
  logic [31:0] hop_chan;
  logic [1:0]  hop_pos;
  logic        hop_repeat;

  out_item_t packets_due[$];
  int        errs;
  int        shown;
  int        checked;

  // Maps x from the span a..b onto c..d, truncating toward zero, kept to 8 bits.
  function automatic logic [7:0] stick_map(longint x, longint a, longint b, longint c,
                                           longint d);
    longint r;
    if (b == a) return c[7:0];
    r = (x - a) * (d - c) / (b - a) + c;
    return r[7:0];
  endfunction

  // Throttle is clamped to the stick range and scaled onto 0..255.
  function automatic logic [7:0] throttle_map(logic [11:0] t);
    int unsigned v;
    int unsigned q;
    if (cfg_max <= cfg_min) return 8'd0;
    v = 32'(t);
    if (v < cfg_min) v = 32'(cfg_min);
    if (v > cfg_max) v = 32'(cfg_max);
    q = (v - cfg_min) * 255 / (cfg_max - cfg_min);
    return q[7:0];
  endfunction

  function automatic string field_name(int k);
    case (k)
      0: return "byte0";
      1: return "byte1";
      2: return "byte2";
      3: return "byte3";
      4: return "byte4";
      5: return "byte5";
      6: return "byte6";
      7: return "byte7";
      8: return "byte8";
      9: return "check_byte";
      default: return "rf_channel";
    endcase
  endfunction

  // New channel list from the low five bits of the transmitter id.
  task automatic reseed_hops(input logic [4:0] seed);
    logic [4:0] lv;
    int         i;
    for (i = 0; i < HOP_CHANNELS; i++) begin
      if (seed < 5'h10) begin
        lv = (seed == 5'h06) ? 5'h07 : seed;
        hop_chan[8*i +: 8] = HOPS_LOW[8*i +: 8] + {3'b000, lv};
      end else if (seed < 5'h18) begin
        hop_chan[8*i +: 8] = HOPS_MID[8*i +: 8] + {5'b00000, seed[2:0]};
        if (seed == 5'h16 && i < 2) hop_chan[8*i +: 8] = hop_chan[8*i +: 8] + 8'd1;
      end else if (seed < 5'h1e) begin
        hop_chan[8*i +: 8] = HOPS_HIGH[8*i +: 8] + {5'b00000, seed[2:0]};
      end else if (seed == 5'h1e) begin
        hop_chan[8*i +: 8] = HOPS_SEED_1E[8*i +: 8];
      end else begin
        hop_chan[8*i +: 8] = HOPS_SEED_1F[8*i +: 8];
      end
    end
  endtask

  // Works out the packet, if any, that one accepted command causes.
  task automatic take_command(input in_item_t it);
    out_item_t p;
    logic      makes_packet;
    makes_packet = 1'b0;
    p = '0;
    case (it.cmd)
      CMD_FINISH: begin
        reseed_hops(tx_id[4:0]);
        hop_pos    = 2'd0;
        hop_repeat = 1'b0;
      end
      CMD_BIND: begin
        makes_packet = 1'b1;
        p.byte0 = PKT_BIND_HEAD;
        p.byte1 = tx_id[31:24];
        p.byte2 = tx_id[23:16];
        p.byte3 = tx_id[15:8];
        p.byte4 = tx_id[7:0];
        p.byte5 = PKT_BIND_FILL;
        p.byte6 = PKT_BIND_FILL;
        p.byte7 = PKT_BIND_FILL;
      end
      CMD_DATA: begin
        makes_packet = 1'b1;
        p.byte0 = throttle_map(it.throttle);
        // Elevator puts the direction bit below center; rudder and aileron above it.
        p.byte1 = (it.elevator < cfg_mid) ? stick_map(it.elevator, cfg_mid, cfg_min, 128, 255)
                                          : stick_map(it.elevator, cfg_mid, cfg_max, 0, 127);
        p.byte2 = (it.rudder < cfg_mid) ? stick_map(it.rudder, cfg_mid, cfg_min, 0, 127)
                                        : stick_map(it.rudder, cfg_mid, cfg_max, 128, 255);
        p.byte3 = (it.aileron < cfg_mid) ? stick_map(it.aileron, cfg_mid, cfg_min, 0, 127)
                                         : stick_map(it.aileron, cfg_mid, cfg_max, 128, 255);
        p.byte4 = (it.video_on ? vid_mask : 8'h00) | (it.picture_on ? pic_mask : 8'h00);
        p.byte5 = (p.byte1 >> 2) | PKT_ELE_TRIM;
        p.byte6 = (p.byte2 >> 2) | (it.flip_on ? flp_mask : 8'h00);
        p.byte7 = (p.byte3 >> 2) | (it.headless_on ? hdl_mask : 8'h00);
      end
      default: ;
    endcase
    if (makes_packet) begin
      p.check_byte = (p.byte0 ^ p.byte1 ^ p.byte2 ^ p.byte3 ^ p.byte4 ^ p.byte5 ^ p.byte6
                      ^ p.byte7 ^ p.byte8) + PKT_CHECK_ADD;
      p.rf_channel = hop_chan[8*hop_pos +: 8];
      packets_due.push_back(p);
      // Each channel carries two packets in a row.
      if (hop_repeat) hop_pos = hop_pos + 2'd1;
      hop_repeat = ~hop_repeat;
    end
  endtask

  task automatic write_copy(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_STICK_MIN:      cfg_min  = val[11:0];
      CFG_STICK_MID:      cfg_mid  = val[11:0];
      CFG_STICK_MAX:      cfg_max  = val[11:0];
      CFG_TRANSMITTER_ID: tx_id    = val;
      CFG_VIDEO_MASK:     vid_mask = val[7:0];
      CFG_PICTURE_MASK:   pic_mask = val[7:0];
      CFG_FLIP_MASK:      flp_mask = val[7:0];
      CFG_HEADLESS_MASK:  hdl_mask = val[7:0];
      default: ;
    endcase
  endtask

  // Compares one result transfer, field by field, with the oldest packet due.
  task automatic check_packet(input out_item_t got);
    out_item_t   want;
    logic [87:0] wb, gb;
    int          k;
    int          first_bad;
    if (packets_due.size() == 0) begin
      errs++;
      if (shown < 10) begin
        shown++;
        $display("[%0t] unexpected packet %h", $time, got);
      end
    end else begin
      want = packets_due.pop_front();
      wb = want;
      gb = got;
      first_bad = -1;
      for (k = 0; k < OUT_FIELDS; k++) begin
        if (wb[87-8*k -: 8] !== gb[87-8*k -: 8]) begin
          errs++;
          if (first_bad < 0) first_bad = k;
        end
      end
      if (first_bad >= 0 && shown < 10) begin
        shown++;
        $display("[%0t] packet %0d: %s expected %02h got %02h (expected %h, got %h)",
                 $time, checked, field_name(first_bad), wb[87-8*first_bad -: 8],
                 gb[87-8*first_bad -: 8], want, got);
      end
      checked++;
    end
  endtask

  // Transfers are sampled at the rising edge; the counters are driven with nonblocking assignments.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_min    = 12'd1000;
      cfg_mid    = 12'd1500;
      cfg_max    = 12'd2000;
      tx_id      = 32'h0;
      vid_mask   = 8'h10;
      pic_mask   = 8'h08;
      flp_mask   = 8'h40;
      hdl_mask   = 8'h80;
      hop_chan   = HOPS_AT_RESET;
      hop_pos    = 2'd0;
      hop_repeat = 1'b0;
      packets_due.delete();
      errs    = 0;
      shown   = 0;
      checked = 0;
    end else begin
      if (out_valid && !out_stall) check_packet(out_data);
      if (cfg_valid && cfg_ready) write_copy(cfg_index, cfg_data);
      if (in_valid && !in_stall) take_command(in_data);
    end
    fail_count    <= errs;
    pending_count <= packets_due.size();
    checked_count <= checked;
  end

endmodule

// File: test/rc_packet_builder_hopper_tb.sv
// Testbench top for rc_packet_builder_hopper: clock, reset, stimulus and the verdict.
// Depends on rcpb_pkg, the block itself and rcpb_packet_checker.

module rc_packet_builder_hopper_tb;
  import rcpb_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         GAP_MAX     = 17;
  localparam int         SETTLE      = 40;
  localparam int         SEED_COUNT  = 32;
  localparam int         PHASE_ITEMS = 28;
  localparam int         RUN_LIMIT   = 500000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          fail_count;
  int          pending_count;
  int          checked_count;
  int          cycle_count = 0;
  int          items_sent  = 0;
  int          settings_used = 0;
  logic        no_idle = 1'b0;
  logic [11:0] cur_lo = 12'd1000, cur_mid = 12'd1500, cur_hi = 12'd2000;

  rc_packet_builder_hopper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcpb_packet_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each transfer.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic in_item_t stick_item(logic [11:0] t, logic [11:0] e, logic [11:0] r,
                                          logic [11:0] a, logic [3:0] flags);
    in_item_t it;
    it.cmd         = CMD_DATA;
    it.throttle    = t;
    it.elevator    = e;
    it.rudder      = r;
    it.aileron     = a;
    it.video_on    = flags[3];
    it.picture_on  = flags[2];
    it.flip_on     = flags[1];
    it.headless_on = flags[0];
    return it;
  endfunction

  // A command other than data, with noise in the unused fields.
  function automatic in_item_t cmd_item(logic [1:0] c);
    in_item_t it;
    it = stick_item(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                    12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                    4'($urandom_range(0, 15)));
    it.cmd = c;
    return it;
  endfunction

  // Stick values lean toward the configured range and its edges.
  function automatic logic [11:0] pick_stick();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'hfff;
      2: return cur_mid;
      3: return cur_lo;
      4: return cur_hi;
      5, 6: return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(cur_lo, cur_hi));
    endcase
  endfunction

  function automatic in_item_t random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72)
      return stick_item(pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                        4'($urandom_range(0, 15)));
    else if (r < 86)
      return cmd_item(CMD_BIND);
    else if (r < 94)
      return cmd_item(CMD_FINISH);
    else
      return cmd_item(CMD_SPARE);
  endfunction

  // One input transfer after a random gap.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  // Holds off new input until every packet due has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // Rewrites every register once the block has gone quiet.
  task automatic set_all(input logic [11:0] lo, input logic [11:0] mid, input logic [11:0] hi,
                         input logic [31:0] id, input logic [31:0] masks);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_STICK_MIN, {20'd0, lo});
    write_reg(CFG_STICK_MID, {20'd0, mid});
    write_reg(CFG_STICK_MAX, {20'd0, hi});
    write_reg(CFG_TRANSMITTER_ID, id);
    write_reg(CFG_VIDEO_MASK, {24'd0, masks[31:24]});
    write_reg(CFG_PICTURE_MASK, {24'd0, masks[23:16]});
    write_reg(CFG_FLIP_MASK, {24'd0, masks[15:8]});
    write_reg(CFG_HEADLESS_MASK, {24'd0, masks[7:0]});
    cfg_valid <= 1'b0;
    cur_lo  = lo;
    cur_mid = mid;
    cur_hi  = hi;
    settings_used++;
  endtask

  initial begin
    int          phase;
    int          k;
    int          mode;
    logic [11:0] lo, mid, hi;
    logic [31:0] masks;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: stick extremes, center and range edges, every command.
    send_item(stick_item(12'd0, 12'd0, 12'd0, 12'd0, 4'b0000));
    send_item(stick_item(12'hfff, 12'hfff, 12'hfff, 12'hfff, 4'b1111));
    send_item(stick_item(12'd1500, 12'd1500, 12'd1500, 12'd1500, 4'b1010));
    send_item(stick_item(12'd1000, 12'd1000, 12'd1000, 12'd1000, 4'b0101));
    send_item(stick_item(12'd2000, 12'd2000, 12'd2000, 12'd2000, 4'b1100));
    send_item(stick_item(12'd999, 12'd1499, 12'd1501, 12'd2001, 4'b0011));
    send_item(cmd_item(CMD_BIND));
    send_item(cmd_item(CMD_SPARE));
    send_item(cmd_item(CMD_FINISH));
    send_item(stick_item(12'd1234, 12'd1800, 12'd1200, 12'd1650, 4'b1001));

    // All three stick values equal: empty throttle range and zero spans.
    set_all(12'd2048, 12'd2048, 12'd2048, 32'h0, 32'h0);
    send_item(stick_item(12'd2048, 12'd100, 12'd3000, 12'd2048, 4'b1111));
    send_item(stick_item(12'hfff, 12'd0, 12'hfff, 12'd0, 4'b1111));

    // Inverted range, all-ones id and masks; the id seeds the last special hop list.
    set_all(12'd3000, 12'd1000, 12'd500, 32'hffff_ffff, 32'hffff_ffff);
    send_item(cmd_item(CMD_BIND));
    send_item(cmd_item(CMD_FINISH));
    send_item(stick_item(12'd0, 12'hfff, 12'd700, 12'd2500, 4'b1111));
    send_item(stick_item(12'd3500, 12'd900, 12'd1000, 12'd200, 4'b0101));

    // Center on the low end, then on the high end; the mid-range and skipped-six seeds.
    set_all(12'd0, 12'd0, 12'hfff, 32'h1234_5696, 32'h0102_0408);
    send_item(cmd_item(CMD_FINISH));
    send_item(stick_item(12'd0, 12'd0, 12'hfff, 12'd2000, 4'b1111));
    send_item(stick_item(12'hfff, 12'hfff, 12'd0, 12'd1, 4'b0110));
    set_all(12'd0, 12'hfff, 12'hfff, 32'h8765_4306, 32'h8040_2010);
    send_item(cmd_item(CMD_FINISH));
    send_item(stick_item(12'd17, 12'd4000, 12'hfff, 12'd0, 4'b1001));
    send_item(cmd_item(CMD_BIND));

    // One phase per hop-list seed, each with freshly drawn registers.
    for (phase = 0; phase < SEED_COUNT; phase++) begin
      mode = $urandom_range(0, 4);
      case (mode)
        0, 1: begin
          lo  = 12'($urandom_range(0, 1500));
          hi  = 12'($urandom_range(2500, 4095));
          mid = 12'($urandom_range(lo, hi));
        end
        2: begin
          lo  = 12'($urandom_range(0, 4095));
          mid = 12'($urandom_range(0, 4095));
          hi  = 12'($urandom_range(0, 4095));
        end
        3: begin
          lo  = 12'd1000;
          mid = 12'd1500;
          hi  = 12'd2000;
        end
        default: begin
          lo  = 12'($urandom_range(0, 4095));
          hi  = 12'($urandom_range(0, 4095));
          mid = $urandom_range(0, 1) ? lo : hi;
        end
      endcase
      masks = $urandom();
      if (phase % 8 == 3) masks = 32'h0;
      if (phase % 8 == 5) masks = 32'hffff_ffff;
      set_all(lo, mid, hi, {27'($urandom_range(0, 32'h07ff_ffff)), phase[4:0]}, masks);
      no_idle = ($urandom_range(0, 3) == 0);
      send_item(cmd_item(CMD_FINISH));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && phase % 4 == 1) wait_drained();
        send_item(random_item());
      end
      no_idle = 1'b0;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d items under %0d register settings, all %0d hop seeds; %0d packets checked.",
             items_sent, settings_used, SEED_COUNT, checked_count);
    if (fail_count == 0 && pending_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
